FILE: hdl/dnc_pkg.sv
// Package for the day number to calendar date converter.
// Holds widths, calendar constants, result and status types and small helpers.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dnc_pkg;

    // Width of the day count; only this many bits of a day number are used.
    localparam int DAY_BITS = 16;
    localparam int LEN_BITS = 9;

    localparam logic [11:0]         YEAR_BASE  = 12'd2000;
    localparam logic [LEN_BITS-1:0] LEN_LEAP   = 9'd366;
    localparam logic [LEN_BITS-1:0] LEN_COMMON = 9'd365;
    localparam logic [LEN_BITS-1:0] LEN_FEB_LEAP = 9'd29;
    localparam logic [LEN_BITS-1:0] LEN_FEB    = 9'd28;
    localparam logic [LEN_BITS-1:0] LEN_SHORT  = 9'd30;
    localparam logic [LEN_BITS-1:0] LEN_LONG   = 9'd31;
    localparam logic [2:0]          WEEK_DAYS  = 3'd7;
    localparam logic [6:0]          CENTURY_LAST = 7'd99;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic [2:0]  weekday;
    } dnc_date_t;

    typedef struct packed {
        logic idle;
        logic done;
    } dnc_status_t;

    typedef struct packed {
        logic [DAY_BITS-1:0] diff;
        logic                ge;
    } dnc_sub_t;

    function automatic logic [LEN_BITS-1:0] month_len(input logic [3:0] m, input logic leap);
        logic [LEN_BITS-1:0] len;
        case (m)
            MONTH_FEB: len = leap ? LEN_FEB_LEAP : LEN_FEB;
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = LEN_SHORT;
            default: len = LEN_LONG;
        endcase
        return len;
    endfunction

    // Reduces a small value modulo 7 by repeated conditional subtraction.
    function automatic logic [2:0] mod7(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= {3'd0, WEEK_DAYS}) begin
                r = r - {3'd0, WEEK_DAYS};
            end
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/dnc_in_if.sv
// Input channel carrying one day number per transfer.
// Depends on dnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dnc_in_if;
    import dnc_pkg::*;

    logic                valid;
    logic                ready;
    logic [DAY_BITS-1:0] day_number;

    modport source (output valid, output day_number, input ready);
    modport sink (input valid, input day_number, output ready);
endinterface

`default_nettype wire

FILE: hdl/dnc_out_if.sv
// Output channel carrying one calendar date per transfer.
// Depends on dnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dnc_out_if;
    import dnc_pkg::*;

    logic        valid;
    logic        ready;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;

    modport source (output valid, output year, output month, output day_of_month,
                    output weekday, input ready);
    modport sink (input valid, input year, input month, input day_of_month,
                  input weekday, output ready);
endinterface

`default_nettype wire

FILE: hdl/dnc_sub_unit.sv
// Shared subtract and compare unit: remaining days minus a year or month length.
// Depends on dnc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnc_sub_unit (
    input  wire logic [dnc_pkg::DAY_BITS-1:0] rest,
    input  wire logic [dnc_pkg::LEN_BITS-1:0] len,
    output dnc_pkg::dnc_sub_t                 res
);
    import dnc_pkg::*;

    logic [DAY_BITS:0] wide_diff;

    assign wide_diff = {1'b0, rest} - {{(DAY_BITS + 1 - LEN_BITS){1'b0}}, len};
    assign res.diff  = wide_diff[DAY_BITS-1:0];
    assign res.ge    = ~wide_diff[DAY_BITS];
endmodule

`default_nettype wire

FILE: hdl/dnc_seq.sv
// Sequencer that walks years and then months through the shared subtract unit.
// Depends on dnc_pkg and dnc_sub_unit.
`timescale 1ns / 1ps
`default_nettype none

module dnc_seq (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [dnc_pkg::DAY_BITS-1:0] day,
    input  wire logic                         finish_ok,
    output dnc_pkg::dnc_status_t              status,
    output dnc_pkg::dnc_date_t                date
);
    import dnc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_YEAR   = 4'b0010,
        S_MONTH  = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [DAY_BITS-1:0] rest_reg, rest_next;
    logic [11:0]         year_reg, year_next;
    logic [6:0]          c100_reg, c100_next;
    logic [1:0]          c400_reg, c400_next;
    logic [3:0]          month_reg, month_next;
    logic [2:0]          wd_reg, wd_next;

    logic                leap;
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] mlen_excess;
    dnc_sub_t            sub_res;

    // Year counters: c100 counts years within the century, c400 centuries within 400.
    assign leap = ((year_reg[1:0] == 2'd0) && (c100_reg != 7'd0)) ||
                  ((c100_reg == 7'd0) && (c400_reg == 2'd0));

    always_comb
    begin
        if (state_reg == S_MONTH)
        begin
            len = month_len(month_reg, leap);
        end
        else
        begin
            len = leap ? LEN_LEAP : LEN_COMMON;
        end
    end

    assign mlen_excess = len - LEN_FEB;

    dnc_sub_unit u_sub (
        .rest (rest_reg),
        .len  (len),
        .res  (sub_res)
    );

    always_comb
    begin
        state_next = state_reg;
        rest_next  = rest_reg;
        year_next  = year_reg;
        c100_next  = c100_reg;
        c400_next  = c400_reg;
        month_next = month_reg;
        wd_next    = wd_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    rest_next  = day;
                    year_next  = YEAR_BASE;
                    c100_next  = 7'd0;
                    c400_next  = 2'd0;
                    month_next = MONTH_JAN;
                    wd_next    = 3'd0;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                if (sub_res.ge)
                begin
                    rest_next = sub_res.diff;
                    year_next = year_reg + 12'd1;
                    if (c100_reg == CENTURY_LAST)
                    begin
                        c100_next = 7'd0;
                        c400_next = c400_reg + 2'd1;
                    end
                    else
                    begin
                        c100_next = c100_reg + 7'd1;
                    end
                    // A year of 365 days moves the weekday by one, a leap year by two.
                    wd_next = mod7({3'd0, wd_reg} + (leap ? 6'd2 : 6'd1));
                end
                else
                begin
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (sub_res.ge && (month_reg != MONTH_DEC))
                begin
                    rest_next  = sub_res.diff;
                    month_next = month_reg + 4'd1;
                    wd_next    = mod7({3'd0, wd_reg} + {3'd0, mlen_excess[2:0]});
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (finish_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rest_reg  <= rest_next;
        year_reg  <= year_next;
        c100_reg  <= c100_next;
        c400_reg  <= c400_next;
        month_reg <= month_next;
        wd_reg    <= wd_next;
    end

    assign status.idle = (state_reg == S_IDLE);
    assign status.done = (state_reg == S_FINISH) && finish_ok;

    // Only the remainder within the month is left, so its low five bits suffice.
    assign date.year         = year_reg;
    assign date.month        = month_reg;
    assign date.day_of_month = rest_reg[4:0] + 5'd1;
    assign date.weekday      = mod7({3'd0, wd_reg} + {1'b0, rest_reg[4:0]});
endmodule

`default_nettype wire

FILE: hdl/day_number_to_calendar_date.sv
// Top level of the day number to calendar date converter: channels and result register.
// Depends on dnc_pkg, dnc_in_if, dnc_out_if and dnc_seq.
//
//  Channel   Direction  Payload
//  request   in         day_number
//  result    out        year, month, day_of_month, weekday
//
// One conversion walks whole years first, then whole months.
// The year and month walks share one subtract and compare unit.
// Reset clears the sequencer and the result valid flag.
// The next request is taken once the previous result sits in the result register,
// even while it waits to be taken; a stalled result holds the sequencer in its last step.
`timescale 1ns / 1ps
`default_nettype none

module day_number_to_calendar_date (
    input  wire logic clk,
    input  wire logic rst_n,
    dnc_in_if.sink    request,
    dnc_out_if.source result
);
    import dnc_pkg::*;

    dnc_status_t status;
    dnc_date_t   date;
    dnc_date_t   out_reg;
    logic        out_valid_reg, out_valid_next;
    logic        finish_ok;

    assign finish_ok = !out_valid_reg || result.ready;

    dnc_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (request.valid && request.ready),
        .day       (request.day_number),
        .finish_ok (finish_ok),
        .status    (status),
        .date      (date)
    );

    assign request.ready = status.idle;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (status.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
        begin
            out_reg <= date;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.year         = out_reg.year;
    assign result.month        = out_reg.month;
    assign result.day_of_month = out_reg.day_of_month;
    assign result.weekday      = out_reg.weekday;

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        request.valid && request.ready |=> !request.ready)
        else $error("request taken while a conversion was starting");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        status.done |-> (!out_valid_reg || result.ready))
        else $error("pending result overwritten");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.month >= MONTH_JAN) && (result.month <= MONTH_DEC))
        else $error("month out of range");

    a_weekday_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.weekday < WEEK_DAYS) && (result.day_of_month != 5'd0))
        else $error("weekday or day of month out of range");
endmodule

`default_nettype wire

FILE: tb/day_number_to_calendar_date_test.sv
// Self-checking testbench for the day number to calendar date converter.
// Drives day numbers over dnc_in_if, checks dates on dnc_out_if against a local calendar walk.
// Depends on dnc_pkg, dnc_in_if, dnc_out_if and day_number_to_calendar_date.
`timescale 1ns / 1ps

module day_number_to_calendar_date_test;
    import dnc_pkg::*;

    localparam int RANDOM_DAYS  = 450;
    localparam int HOLD_START   = 4000;
    localparam int HOLD_CYCLES  = 800;
    localparam int SETTLE       = 200;
    localparam int QUIET_LIMIT  = 20000;

    typedef enum logic [2:0] {
        SATURDAY, SUNDAY, MONDAY, TUESDAY, WEDNESDAY, THURSDAY, FRIDAY
    } weekday_t;

    typedef struct {
        logic [DAY_BITS-1:0] day;
        bit                  fixed;
        dnc_date_t           date;
    } day_row_t;

    logic clk = 1'b0;
    logic rst_n;

    dnc_in_if  request_ch ();
    dnc_out_if result_ch ();

    day_number_to_calendar_date i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(request_ch),
        .result (result_ch)
    );

    // Rows with a typed date are read straight off the calendar; the rest go to the predictor.
    day_row_t directed_days [23] = '{
        '{16'd0,     1'b1, '{12'd2000, MONTH_JAN, 5'd1,  SATURDAY}},
        '{16'd59,    1'b1, '{12'd2000, MONTH_FEB, 5'd29, TUESDAY}},
        '{16'd365,   1'b1, '{12'd2000, MONTH_DEC, 5'd31, SUNDAY}},
        '{16'd366,   1'b1, '{12'd2001, MONTH_JAN, 5'd1,  MONDAY}},
        '{16'hFFFF,  1'b0, '0},
        '{16'd1,     1'b0, '0},
        '{16'd6,     1'b0, '0},
        '{16'd7,     1'b0, '0},
        '{16'd30,    1'b0, '0},
        '{16'd31,    1'b0, '0},
        '{16'd58,    1'b0, '0},
        '{16'd60,    1'b0, '0},
        '{16'd1460,  1'b0, '0},
        '{16'd1461,  1'b0, '0},
        '{16'd36524, 1'b0, '0},
        '{16'd36525, 1'b0, '0},
        '{16'd36583, 1'b0, '0},
        '{16'd36584, 1'b0, '0},
        '{16'h5555,  1'b0, '0},
        '{16'hAAAA,  1'b0, '0},
        '{16'h7FFF,  1'b0, '0},
        '{16'h8000,  1'b0, '0},
        '{16'hFFFE,  1'b0, '0}
    };

    int unsigned month_days [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    day_row_t  pending_rows [$];
    dnc_date_t dates_due [$];
    day_row_t  accepted_row;
    dnc_date_t due_date;
    int unsigned days_sent = 0;
    int unsigned dates_seen = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit leap_year(input int unsigned yr);
        return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    endfunction

    // Walks whole years from the base year, then whole months, as the block does.
    function automatic dnc_date_t calendar_of(input logic [DAY_BITS-1:0] day);
        int unsigned left;
        int unsigned yr;
        int unsigned mon;
        int unsigned span;
        bit          leap;
        dnc_date_t   d;
        left = day;
        yr = YEAR_BASE;
        span = leap_year(yr) ? LEN_LEAP : LEN_COMMON;
        while (left >= span)
        begin
            left -= span;
            yr++;
            span = leap_year(yr) ? LEN_LEAP : LEN_COMMON;
        end
        leap = leap_year(yr);
        mon = MONTH_JAN;
        while (mon < MONTH_DEC)
        begin
            span = month_days[mon] + ((mon == MONTH_FEB && leap) ? 1 : 0);
            if (left < span)
            begin
                break;
            end
            left -= span;
            mon++;
        end
        d.year = 12'(yr);
        d.month = 4'(mon);
        d.day_of_month = 5'(left + 1);
        d.weekday = 3'(day % WEEK_DAYS);
        return d;
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Offers one day number; bursts of back-to-back transfers are separated by random gaps.
    task automatic offer_day(input day_row_t row);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 8);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 4);
            if (gap != 0)
            begin
                request_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pending_rows.push_back(row);
        request_ch.valid <= 1'b1;
        request_ch.day_number <= row.day;
        do @(posedge clk); while (!request_ch.ready);
        days_sent++;
    endtask

    task automatic drain_dates();
        request_ch.valid <= 1'b0;
        do @(posedge clk); while (dates_seen != days_sent);
    endtask

    initial
    begin : stimulus
        day_row_t row;
        rst_n <= 1'b0;
        request_ch.valid <= 1'b0;
        request_ch.day_number <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_days[i])
        begin
            offer_day(directed_days[i]);
        end
        drain_dates();
        for (int i = 0; i < RANDOM_DAYS; i++)
        begin
            // Halfway through, let the converter run completely empty once.
            if (i == RANDOM_DAYS / 2)
            begin
                drain_dates();
            end
            row.fixed = 1'b0;
            row.date = '0;
            if ($urandom_range(0, 3) == 0)
            begin
                row.day = DAY_BITS'($urandom_range(0, 1500));
            end
            else
            begin
                row.day = DAY_BITS'($urandom_range(0, (1 << DAY_BITS) - 1));
            end
            offer_day(row);
        end
        drain_dates();
        repeat (SETTLE) @(posedge clk);
        if (dates_due.size() != 0)
        begin
            flag_mismatch($sformatf("%0d dates never arrived", dates_due.size()));
        end
        if (mismatches == 0)
        begin
            $display("day_number_to_calendar_date regression: pass");
        end
        else
        begin
            $display("day_number_to_calendar_date regression: fail");
        end
        $finish;
    end

    // The result side alternates between stall patterns, and holds off once for a long
    // stretch so that the converter fills up and stalls the request side.
    initial
    begin : result_sink
        int unsigned rx_cycles;
        int unsigned ready_pct;
        result_ch.ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        rx_cycles = 0;
        ready_pct = 100;
        forever
        begin
            if (rx_cycles == HOLD_START)
            begin
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_cycles += HOLD_CYCLES;
            end
            if (rx_cycles % 256 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 50;
                    2: ready_pct = 10;
                    default: ready_pct = 90;
                endcase
            end
            result_ch.ready <= ($urandom_range(1, 100) <= ready_pct);
            @(posedge clk);
            rx_cycles++;
        end
    end

    always @(posedge clk)
    begin
        if (request_ch.valid && request_ch.ready)
        begin
            accepted_row = pending_rows.pop_front();
            dates_due.push_back(accepted_row.fixed ? accepted_row.date
                                                   : calendar_of(request_ch.day_number));
        end
        if (result_ch.valid && result_ch.ready)
        begin
            dates_seen++;
            if (dates_due.size() == 0)
            begin
                flag_mismatch("date transfer with nothing expected");
            end
            else
            begin
                due_date = dates_due.pop_front();
                if (result_ch.year !== due_date.year)
                begin
                    flag_mismatch($sformatf("year %0d, expected %0d",
                                            result_ch.year, due_date.year));
                end
                if (result_ch.month !== due_date.month)
                begin
                    flag_mismatch($sformatf("month %0d, expected %0d",
                                            result_ch.month, due_date.month));
                end
                if (result_ch.day_of_month !== due_date.day_of_month)
                begin
                    flag_mismatch($sformatf("day_of_month %0d, expected %0d",
                                            result_ch.day_of_month, due_date.day_of_month));
                end
                if (result_ch.weekday !== due_date.weekday)
                begin
                    flag_mismatch($sformatf("weekday %0d, expected %0d",
                                            result_ch.weekday, due_date.weekday));
                end
            end
        end
        if ((request_ch.valid && request_ch.ready) || (result_ch.valid && result_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : watchdog
        do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
        $display("day_number_to_calendar_date regression: fail");
        $finish;
    end

endmodule
